@@ rtl/core/pht_pkg.sv @@
package pht_pkg;

	localparam int ID_W = 64;
	localparam int SEQ_W = 32;
	localparam int TIME_W = 48;
	localparam int ADDR_W = 64;
	localparam int TTL_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam int THR_W = 7;

	localparam logic [THR_W-1:0] SWEEP_THRESHOLD_RESET = 7'd10;
	localparam logic [CFG_DATA_W-1:0] LIFETIME_RESET = 32'd10000;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [9:0] MS_PER_S = 10'd1000;

	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 1'd1;

	typedef enum logic [2:0] {
		REQ_UPDATE = 3'd0,
		REQ_STALE = 3'd1,
		REQ_ACK = 3'd2,
		REQ_RECV = 3'd3,
		REQ_DELETE = 3'd4,
		REQ_FRESHEN = 3'd5,
		REQ_CLEAR = 3'd6,
		REQ_NONE = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MISSING = 2'd1,
		ST_NO_ROOM = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic [ID_W-1:0] id_high;
		logic [ID_W-1:0] id_low;
		logic [SEQ_W-1:0] seq_num;
		logic ack_wanted;
		logic [TTL_W-1:0] ttl_seconds;
		logic [ADDR_W-1:0] node_addr;
		logic node_addr_valid;
		logic [ADDR_W-1:0] dest_addr;
		logic [TIME_W-1:0] now_ms;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic flag;
		logic [SEQ_W-1:0] seq_out;
		logic [ADDR_W-1:0] addr_out;
	} result_t;

endpackage

@@ rtl/core/pht_expiry.sv @@
module pht_expiry (
	input logic clk,
	input logic load,
	input logic [pht_pkg::TIME_W-1:0] now_ms,
	input logic [pht_pkg::TTL_W-1:0] ttl_seconds,
	input logic [pht_pkg::CFG_DATA_W-1:0] lifetime_ms,
	output logic [pht_pkg::TIME_W-1:0] expiry
);
	import pht_pkg::*;

	logic [TTL_W+9:0] ttl_ms_s1;
	logic [TIME_W-1:0] now_s1;
	logic [CFG_DATA_W-1:0] life_s1;
	logic [TIME_W+1:0] sum;

	always_ff @(posedge clk) begin
		if (load) begin
			ttl_ms_s1 <= ttl_seconds * MS_PER_S;
			now_s1 <= now_ms;
			life_s1 <= lifetime_ms;
		end
	end

	assign sum = {2'b0, now_s1} + {{(TIME_W-TTL_W-8){1'b0}}, ttl_ms_s1}
		+ {{(TIME_W+2-CFG_DATA_W){1'b0}}, life_s1};

	always_ff @(posedge clk) begin
		expiry <= (sum[TIME_W+1:TIME_W] != 2'b0) ? TIME_MAX : sum[TIME_W-1:0];
	end
endmodule

@@ rtl/core/pht_store.sv @@
module pht_store #(
	parameter int ENTRIES = 64,
	parameter int EW = 6,
	parameter int ROW_W = 1
) (
	input logic clk,
	input logic [EW-1:0] rd_addr,
	output logic [ROW_W-1:0] rd_data,
	input logic wr_en,
	input logic [EW-1:0] wr_addr,
	input logic [ROW_W-1:0] wr_data
);
	logic [ROW_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

@@ rtl/core/publication_history_table_top.sv @@
// One request at a time. Every request except clear, unknown types and a
// received-from whose two addresses match scans the whole entry memory, one
// entry per cycle through its single read port, reads the matching row back
// and finishes; the others go straight to the result. busy is high
// from the transfer of a request until its result strobe; done and result
// are valid for exactly one cycle and cannot be held off by the receiver.
module publication_history_table_top #(
	parameter int TABLE_ENTRIES = 64,
	parameter int SENDERS_PER_ENTRY = 4
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input pht_pkg::req_item_t req,
	output logic done,
	output pht_pkg::result_t result,
	input logic cfg_we,
	input logic [pht_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pht_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pht_pkg::*;

	localparam int EW = $clog2(TABLE_ENTRIES);
	localparam int SW = (SENDERS_PER_ENTRY > 1) ? $clog2(SENDERS_PER_ENTRY) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int SND_W = ADDR_W + SEQ_W;
	localparam int ROW_W = 2*ID_W + SEQ_W + 1 + TIME_W + SENDERS_PER_ENTRY
		+ SENDERS_PER_ENTRY*SND_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_SCAN = 6'b000010,
		S_RD = 6'b000100,
		S_WAIT = 6'b001000,
		S_MOD = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0] id_high;
		logic [ID_W-1:0] id_low;
		logic [SEQ_W-1:0] seq;
		logic ack;
		logic [TIME_W-1:0] expiry;
		logic [SENDERS_PER_ENTRY-1:0] sval;
		logic [SENDERS_PER_ENTRY*SND_W-1:0] snd;
	} row_t;

	state_t state_q;
	req_item_t req_q;
	logic [THR_W-1:0] thr_q;
	logic [CFG_DATA_W-1:0] life_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CW-1:0] count_q;
	logic [EW:0] scan_q;
	logic [EW-1:0] cmp_q;
	logic cmp_v_q;
	logic hit_q;
	logic [EW-1:0] hit_idx_q;
	logic sweep_q;
	logic [TABLE_ENTRIES-1:0] expired_q;
	result_t res_q;
	logic done_q;

	logic [EW-1:0] rd_addr;
	logic [ROW_W-1:0] rd_raw;
	row_t rd_row;
	logic wr_en;
	logic [EW-1:0] wr_addr;
	row_t wr_row;
	logic [TIME_W-1:0] expiry;
	logic free_found;
	logic [EW-1:0] free_idx;

	assign rd_row = row_t'(rd_raw);

	pht_store #(.ENTRIES(TABLE_ENTRIES), .EW(EW), .ROW_W(ROW_W)) u_store (
		.clk(clk), .rd_addr(rd_addr), .rd_data(rd_raw),
		.wr_en(wr_en), .wr_addr(wr_addr), .wr_data(ROW_W'(wr_row))
	);

	pht_expiry u_expiry (
		.clk(clk), .load(start && !busy), .now_ms(req.now_ms),
		.ttl_seconds(req.ttl_seconds), .lifetime_ms(life_q), .expiry(expiry)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = res_q;
	assign rd_addr = (state_q == S_SCAN) ? scan_q[EW-1:0] : hit_idx_q;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = EW'(i);
			end
		end
	end

	// modify stage: row read back at hit_idx_q
	logic [SENDERS_PER_ENTRY-1:0] sv_cur;
	logic seen;
	logic sfree_found;
	logic [SW-1:0] sfree;
	logic first_found;
	logic [ADDR_W-1:0] first_addr;
	logic recv_hit;
	logic [ADDR_W-1:0] sa;
	logic [SEQ_W-1:0] ss;

	always_comb begin
		sv_cur = rd_row.sval;
		seen = 1'b0;
		sfree_found = 1'b0;
		sfree = '0;
		first_found = 1'b0;
		first_addr = '0;
		recv_hit = 1'b0;
		sa = '0;
		ss = '0;
		for (int s = SENDERS_PER_ENTRY - 1; s >= 0; s--) begin
			sa = rd_row.snd[s*SND_W + SEQ_W +: ADDR_W];
			ss = rd_row.snd[s*SND_W +: SEQ_W];
			if (sv_cur[s]) begin
				if (sa == req_q.node_addr) seen = 1'b1;
				first_found = 1'b1;
				first_addr = sa;
				if (req_q.seq_num <= ss && sa == req_q.dest_addr) recv_hit = 1'b1;
			end else begin
				sfree_found = 1'b1;
				sfree = SW'(s);
			end
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = hit_idx_q;
		wr_row = rd_row;
		if (state_q == S_MOD && req_q.req_type == REQ_UPDATE) begin
			wr_en = hit_q || free_found;
			if (!hit_q) begin
				wr_addr = free_idx;
				wr_row.id_high = req_q.id_high;
				wr_row.id_low = req_q.id_low;
				wr_row.sval = SENDERS_PER_ENTRY'(req_q.node_addr_valid);
			end
			wr_row.seq = req_q.seq_num;
			wr_row.ack = req_q.ack_wanted;
			wr_row.expiry = expiry;
			if (req_q.node_addr_valid) begin
				if (!hit_q) begin
					wr_row.snd[0 +: SND_W] = {req_q.node_addr, req_q.seq_num};
				end else if (!seen && sfree_found) begin
					wr_row.sval[sfree] = 1'b1;
					wr_row.snd[sfree*SND_W +: SND_W] = {req_q.node_addr, req_q.seq_num};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= SWEEP_THRESHOLD_RESET;
			life_q <= LIFETIME_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SWEEP_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				CFG_LIFETIME: life_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			count_q <= '0;
			scan_q <= '0;
			cmp_q <= '0;
			cmp_v_q <= 1'b0;
			hit_q <= 1'b0;
			hit_idx_q <= '0;
			sweep_q <= 1'b0;
			expired_q <= '0;
			res_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						scan_q <= '0;
						cmp_v_q <= 1'b0;
						hit_q <= 1'b0;
						expired_q <= '0;
						sweep_q <= ({{(THR_W > CW ? 0 : CW - THR_W + 1){1'b0}}, count_q}
							> {{(CW > THR_W ? 0 : THR_W - CW + 1){1'b0}}, thr_q});
						if (req.req_type == REQ_CLEAR) begin
							res_q <= '0;
							valid_q <= '0;
							count_q <= '0;
							state_q <= S_DONE;
						end else if (req.req_type == REQ_NONE
							|| (req.req_type == REQ_RECV && req.node_addr == req.dest_addr)) begin
							res_q <= '{status: ST_OK, flag: (req.req_type == REQ_RECV),
								seq_out: '0, addr_out: '0};
							state_q <= S_DONE;
						end else begin
							res_q <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cmp_q <= scan_q[EW-1:0];
					cmp_v_q <= (scan_q < (EW+1)'(TABLE_ENTRIES));
					if (cmp_v_q && valid_q[cmp_q]) begin
						if (rd_row.id_high == req_q.id_high && rd_row.id_low == req_q.id_low
							&& !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= cmp_q;
						end
						if (req_q.now_ms >= rd_row.expiry) expired_q[cmp_q] <= 1'b1;
					end
					if (scan_q == (EW+1)'(TABLE_ENTRIES)) begin
						state_q <= S_RD;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_RD: begin
					if (cmp_v_q && valid_q[cmp_q]) begin
						if (rd_row.id_high == req_q.id_high && rd_row.id_low == req_q.id_low
							&& !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= cmp_q;
						end
						if (req_q.now_ms >= rd_row.expiry) expired_q[cmp_q] <= 1'b1;
					end
					cmp_v_q <= 1'b0;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					state_q <= S_DONE;
					case (req_q.req_type)
						REQ_UPDATE: begin
							if (!hit_q) begin
								if (free_found) begin
									valid_q[free_idx] <= 1'b1;
									count_q <= count_q + 1'b1;
								end else begin
									res_q.status <= ST_NO_ROOM;
								end
							end
						end
						REQ_STALE: res_q.flag <= hit_q && (req_q.seq_num <= rd_row.seq);
						REQ_ACK: begin
							if (hit_q && rd_row.ack && first_found) begin
								res_q.seq_out <= rd_row.seq;
								res_q.addr_out <= first_addr;
							end else begin
								res_q.status <= ST_MISSING;
							end
						end
						REQ_RECV: res_q.flag <= hit_q && recv_hit;
						REQ_DELETE: begin
							if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
								count_q <= count_q - 1'b1;
							end else begin
								res_q.status <= ST_MISSING;
							end
						end
						REQ_FRESHEN: begin
							if (sweep_q) begin
								valid_q <= valid_q & ~expired_q;
								count_q <= count_q - CW'($countones(valid_q & expired_q));
							end
						end
						default: ;
					endcase
				end
				S_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ tb/sv/pht_checker.sv @@
`timescale 1ns / 1ps

module pht_checker #(
	parameter int TABLE_ENTRIES = 64,
	parameter int SENDERS_PER_ENTRY = 4
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input pht_pkg::req_item_t req,
	input logic done,
	input pht_pkg::result_t result,
	input logic cfg_we,
	input logic [pht_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [pht_pkg::CFG_DATA_W-1:0] cfg_data,
	output int fail_count,
	output int pending
);
	import pht_pkg::*;

	localparam int NSEND = TABLE_ENTRIES * SENDERS_PER_ENTRY;

	logic [THR_W-1:0] thr;
	logic [CFG_DATA_W-1:0] life;
	logic ent_valid [TABLE_ENTRIES];
	logic [ID_W-1:0] ent_hi [TABLE_ENTRIES];
	logic [ID_W-1:0] ent_lo [TABLE_ENTRIES];
	logic [SEQ_W-1:0] ent_seq [TABLE_ENTRIES];
	logic ent_ack [TABLE_ENTRIES];
	logic [TIME_W-1:0] ent_exp [TABLE_ENTRIES];
	logic snd_valid [NSEND];
	logic [ADDR_W-1:0] snd_addr [NSEND];
	logic [SEQ_W-1:0] snd_seq [NSEND];
	int unsigned ent_count;
	result_t expected_q [$];

	function automatic int find_entry(logic [ID_W-1:0] hi, logic [ID_W-1:0] lo);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (ent_valid[i] && ent_hi[i] == hi && ent_lo[i] == lo)
				return i;
		return -1;
	endfunction

	function automatic void drop_entry(int e);
		ent_valid[e] = 1'b0;
		for (int s = 0; s < SENDERS_PER_ENTRY; s++)
			snd_valid[e * SENDERS_PER_ENTRY + s] = 1'b0;
		if (ent_count > 0)
			ent_count--;
	endfunction

	function automatic void wipe_table();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			ent_valid[i] = 1'b0;
		for (int i = 0; i < NSEND; i++)
			snd_valid[i] = 1'b0;
		ent_count = 0;
	endfunction

	function automatic result_t apply_request(req_item_t r);
		result_t res;
		int e;
		int b;
		int free_s;
		logic seen;
		logic [TIME_W+1:0] sum;
		res = '0;
		e = -1;
		case (req_t'(r.req_type))
			REQ_UPDATE: begin
				e = find_entry(r.id_high, r.id_low);
				if (e < 0) begin
					for (int i = 0; i < TABLE_ENTRIES; i++)
						if (!ent_valid[i]) begin
							e = i;
							break;
						end
					if (e < 0) begin
						res.status = ST_NO_ROOM;
						return res;
					end
					ent_valid[e] = 1'b1;
					ent_hi[e] = r.id_high;
					ent_lo[e] = r.id_low;
					for (int s = 0; s < SENDERS_PER_ENTRY; s++)
						snd_valid[e * SENDERS_PER_ENTRY + s] = 1'b0;
					ent_count++;
				end
				ent_seq[e] = r.seq_num;
				ent_ack[e] = r.ack_wanted;
				if (r.node_addr_valid) begin
					b = e * SENDERS_PER_ENTRY;
					free_s = -1;
					seen = 1'b0;
					for (int s = 0; s < SENDERS_PER_ENTRY; s++) begin
						if (snd_valid[b + s]) begin
							if (snd_addr[b + s] == r.node_addr)
								seen = 1'b1;
						end else if (free_s < 0) begin
							free_s = s;
						end
					end
					if (!seen && free_s >= 0) begin
						snd_valid[b + free_s] = 1'b1;
						snd_addr[b + free_s] = r.node_addr;
						snd_seq[b + free_s] = r.seq_num;
					end
				end
				sum = r.now_ms + r.ttl_seconds * 50'd1000 + life;
				ent_exp[e] = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
			end
			REQ_STALE: begin
				e = find_entry(r.id_high, r.id_low);
				if (e >= 0 && r.seq_num <= ent_seq[e])
					res.flag = 1'b1;
			end
			REQ_ACK: begin
				e = find_entry(r.id_high, r.id_low);
				res.status = ST_MISSING;
				if (e >= 0 && ent_ack[e]) begin
					b = e * SENDERS_PER_ENTRY;
					for (int s = 0; s < SENDERS_PER_ENTRY; s++)
						if (snd_valid[b + s]) begin
							res.status = ST_OK;
							res.seq_out = ent_seq[e];
							res.addr_out = snd_addr[b + s];
							break;
						end
				end
			end
			REQ_RECV: begin
				if (r.node_addr == r.dest_addr) begin
					res.flag = 1'b1;
				end else begin
					e = find_entry(r.id_high, r.id_low);
					if (e >= 0) begin
						b = e * SENDERS_PER_ENTRY;
						for (int s = 0; s < SENDERS_PER_ENTRY; s++)
							if (snd_valid[b + s] && r.seq_num <= snd_seq[b + s]
									&& snd_addr[b + s] == r.dest_addr) begin
								res.flag = 1'b1;
								break;
							end
					end
				end
			end
			REQ_DELETE: begin
				e = find_entry(r.id_high, r.id_low);
				if (e < 0)
					res.status = ST_MISSING;
				else
					drop_entry(e);
			end
			REQ_FRESHEN: begin
				if (ent_count > thr)
					for (int i = 0; i < TABLE_ENTRIES; i++)
						if (ent_valid[i] && r.now_ms >= ent_exp[i])
							drop_entry(i);
			end
			REQ_CLEAR: wipe_table();
			default: ;
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			thr <= SWEEP_THRESHOLD_RESET;
			life <= LIFETIME_RESET;
			wipe_table();
			expected_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %h", result);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (result !== want) begin
						if (fail_count < 10)
							$display({"mismatch: exp st=%0d fl=%0d seq=%h addr=%h",
								" got st=%0d fl=%0d seq=%h addr=%h"},
								want.status, want.flag, want.seq_out, want.addr_out,
								result.status, result.flag, result.seq_out, result.addr_out);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				expected_q.push_back(apply_request(req));
			if (cfg_we) begin
				if (cfg_index == CFG_SWEEP_THRESHOLD)
					thr <= cfg_data[THR_W-1:0];
				else if (cfg_index == CFG_LIFETIME)
					life <= cfg_data;
			end
			pending <= expected_q.size();
		end
	end

endmodule

@@ tb/sv/tb_publication_history_table_top.sv @@
`timescale 1ns / 1ps

module tb_publication_history_table_top;
	import pht_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_item_t req = '0;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int fail_count;
	int pending;
	int cycles = 0;
	int idle_pct = 0;

	logic [ID_W-1:0] id_pool_hi [8];
	logic [ID_W-1:0] id_pool_lo [8];
	logic [ADDR_W-1:0] addr_pool [6];
	logic [TIME_W-1:0] clock_ms = 48'd1000;

	always #10 clk = ~clk;

	publication_history_table_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pht_checker u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_req(req_item_t r);
		while ($urandom_range(99) < idle_pct)
			@(posedge clk);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (80) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic req_item_t make_req(req_t op, int id, int addr, int daddr);
		req_item_t r;
		r = '0;
		r.req_type = op;
		r.id_high = id_pool_hi[id];
		r.id_low = id_pool_lo[id];
		r.seq_num = $urandom_range(20);
		r.ack_wanted = 1'($urandom);
		r.ttl_seconds = TTL_W'($urandom_range(5));
		r.node_addr = addr_pool[addr];
		r.node_addr_valid = $urandom_range(9) != 0;
		r.dest_addr = addr_pool[daddr];
		r.now_ms = clock_ms;
		return r;
	endfunction

	function automatic req_item_t rand_req();
		req_item_t r;
		logic [383:0] raw;
		int k;
		k = $urandom_range(99);
		if (k < 10) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom};
			r = raw[$bits(req_item_t)-1:0];
		end else begin
			r = make_req(req_t'($urandom_range(k < 40 ? 0 : 5)), $urandom_range(7),
				$urandom_range(5), $urandom_range(5));
			if ($urandom_range(15) == 0)
				r.req_type = 3'($urandom_range(7));
		end
		return r;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			clock_ms = clock_ms + $urandom_range(3000);
			send_req(rand_req());
		end
	endtask

	initial begin
		req_item_t r;
		for (int i = 0; i < 8; i++) begin
			id_pool_hi[i] = (i == 7) ? '1 : {$urandom, $urandom};
			id_pool_lo[i] = (i == 0) ? '0 : {$urandom, $urandom};
		end
		for (int i = 0; i < 6; i++)
			addr_pool[i] = (i == 0) ? '0 : (i == 5) ? '1 : {$urandom, $urandom};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fill a sender list past its cap, all ops, extremes
		for (int a = 0; a < 6; a++) begin
			r = make_req(REQ_UPDATE, 7, a, 0);
			r.node_addr_valid = 1'b1;
			r.ack_wanted = 1'b1;
			r.seq_num = '1;
			r.ttl_seconds = '1;
			r.now_ms = '1;
			send_req(r);
		end
		for (int op = 1; op < 8; op++) begin
			r = make_req(req_t'(op), 7, 1, (op == REQ_RECV) ? 1 : 2);
			r.seq_num = '0;
			send_req(r);
		end
		r = make_req(REQ_RECV, 7, 1, 2);
		send_req(r);
		r = make_req(REQ_ACK, 3, 1, 2);
		send_req(r);
		r = make_req(REQ_DELETE, 3, 1, 2);
		send_req(r);

		// fill table to no room, then freshen with low threshold
		write_reg(CFG_SWEEP_THRESHOLD, 7'd0);
		write_reg(CFG_LIFETIME, '0);
		for (int i = 0; i < 66; i++) begin
			r = make_req(REQ_UPDATE, 0, 1, 2);
			r.id_low = ID_W'(i);
			r.ttl_seconds = TTL_W'(i % 2);
			send_req(r);
		end
		r = make_req(REQ_FRESHEN, 0, 1, 2);
		r.now_ms = clock_ms + 500;
		send_req(r);
		r.req_type = REQ_CLEAR;
		send_req(r);

		write_reg(CFG_SWEEP_THRESHOLD, 7'd64);
		write_reg(CFG_LIFETIME, '1);
		idle_pct = 31;
		random_phase(300);
		write_reg(CFG_SWEEP_THRESHOLD, 7'd3);
		write_reg(CFG_LIFETIME, 32'd2000);
		idle_pct = 78;
		random_phase(300);
		write_reg(CFG_SWEEP_THRESHOLD, 7'd127);
		idle_pct = 0;
		random_phase(150);
		write_reg(CFG_SWEEP_THRESHOLD, 7'd1);
		random_phase(100);

		while (pending != 0 || busy)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
